// ===== sv/srsg_pkg.sv =====
// Package for the session replay sequence gate: controller states and verdict codes.
package srsg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_OK      = 2'd0;
    localparam verdict_t VERDICT_RETIRED = 2'd1;
    localparam verdict_t VERDICT_STALE   = 2'd2;
    localparam verdict_t VERDICT_UNUSED  = 2'd3;

endpackage

// ===== sv/session_replay_sequence_gate.sv =====
// Session replay sequence gate: anti-replay filter over retired sessions and per-stream sequences.
//
// Each input transfer carries a 64-bit session identifier, a stream number and a 32-bit
// sequence number, and produces exactly one output transfer with an accept flag and a verdict
// (0 accepted, 1 retired session, 2 sequence not newer). The block handles one frame at a
// time. From the input transfer until the verdict is presented, the single read port of the
// retired-session memory is walked from entry 0 upwards, then the last compare is finished and
// the stream record read, the controller decides and writes back, and the output register is
// loaded. A new frame is taken as soon as the controller is idle, even while the previous
// verdict still waits in the output register. The controller returns to idle between frames,
// but a verdict still held in the output register when the next one is ready keeps the
// controller in its emit state, with the new input refused, until that verdict is taken.
// Retired sessions live in a synchronous memory with per-entry present flags, so no clearing
// pass is needed after reset; the ring overwrites its oldest entry when full. Stream numbers
// at or above STREAM_COUNT are treated as stream 0. A change of session retires the active
// one and drops every stream record, after which any sequence is accepted on each stream;
// otherwise a sequence must be newer by 32-bit serial-number arithmetic.
module session_replay_sequence_gate #(
    parameter int STREAM_COUNT  = 4,
    parameter int RETIRED_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        frame_session,
    input  logic [7:0]         stream,
    input  logic [31:0]        sequence_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output srsg_pkg::verdict_t verdict
);
    import srsg_pkg::*;

    localparam int AW = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
    localparam int SW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

    // Retired-session memory and the per-stream sequence memory.
    logic [63:0] retired_mem [RETIRED_DEPTH];
    logic [31:0] stream_mem  [STREAM_COUNT];

    state_t state_reg, state_next;

    // Control state.
    logic [RETIRED_DEPTH-1:0] present_reg;
    logic [STREAM_COUNT-1:0]  seen_reg;
    logic                     active_valid_reg;
    logic [AW-1:0]            retire_slot_reg;
    logic [AW-1:0]            scan_idx_reg;
    logic                     cmp_vld_reg;
    logic [AW-1:0]            cmp_idx_reg;
    logic                     hit_reg;
    logic                     out_valid_reg;

    // Payload registers.
    logic [63:0]   sid_reg;
    logic [SW-1:0] sidx_reg;
    logic [31:0]   seq_reg;
    logic [63:0]   active_session_reg;
    logic [63:0]   ret_rd_reg;
    logic [31:0]   str_rd_reg;
    verdict_t      verdict_reg;
    logic          accepted_reg;
    verdict_t      verdict_out_reg;

    logic          in_fire;
    logic          out_load;
    logic          entry_hit;
    logic          new_session;
    logic          seen_eff;
    logic [31:0]   seq_diff;
    logic          fresh;
    logic          ret_we;
    logic          str_we;
    logic [SW-1:0] in_sidx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign verdict   = verdict_out_reg;

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Out-of-range stream numbers fold onto stream 0.
    assign in_sidx = (stream >= 8'(STREAM_COUNT)) ? '0 : SW'(stream);

    // A read issued in the previous cycle is compared now, gated by its present flag.
    assign entry_hit = cmp_vld_reg && present_reg[cmp_idx_reg] && (ret_rd_reg == sid_reg);

    // Decision terms, valid in the decide state.
    assign new_session = !active_valid_reg || (active_session_reg != sid_reg);
    assign seen_eff    = !new_session && seen_reg[sidx_reg];
    assign seq_diff    = seq_reg - str_rd_reg;
    assign fresh       = !seen_eff || ((seq_diff != 32'd0) && !seq_diff[31]);

    assign ret_we = (state_reg == ST_DECIDE) && !hit_reg && new_session && active_valid_reg;
    assign str_we = (state_reg == ST_DECIDE) && !hit_reg && fresh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == AW'(RETIRED_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg      <= '0;
            seen_reg         <= '0;
            active_valid_reg <= 1'b0;
            retire_slot_reg  <= '0;
            scan_idx_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            cmp_idx_reg      <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= scan_idx_reg;

            if (in_fire)
            begin
                hit_reg      <= 1'b0;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (entry_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (state_reg == ST_SCAN)
                begin
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                end
            end

            if ((state_reg == ST_DECIDE) && !hit_reg)
            begin
                if (ret_we)
                begin
                    present_reg[retire_slot_reg] <= 1'b1;
                    if (retire_slot_reg == AW'(RETIRED_DEPTH - 1))
                    begin
                        retire_slot_reg <= '0;
                    end
                    else
                    begin
                        retire_slot_reg <= retire_slot_reg + AW'(1);
                    end
                end
                active_valid_reg <= 1'b1;
                // A new session drops every stream record at once; its first frame is always
                // fresh, so only the record of this frame's stream is left marked.
                if (new_session)
                begin
                    seen_reg <= STREAM_COUNT'(1) << sidx_reg;
                end
                else if (fresh)
                begin
                    seen_reg[sidx_reg] <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sid_reg  <= frame_session;
            sidx_reg <= in_sidx;
            seq_reg  <= sequence_req;
        end

        if ((state_reg == ST_DECIDE) && !hit_reg && new_session)
        begin
            active_session_reg <= sid_reg;
        end

        if (state_reg == ST_DECIDE)
        begin
            if (hit_reg)
            begin
                verdict_reg <= VERDICT_RETIRED;
            end
            else if (fresh)
            begin
                verdict_reg <= VERDICT_OK;
            end
            else
            begin
                verdict_reg <= VERDICT_STALE;
            end
        end

        if (out_load)
        begin
            verdict_out_reg <= verdict_reg;
            accepted_reg    <= (verdict_reg == VERDICT_OK);
        end
    end

    // Retired-session memory: one read a cycle during the walk, one write on retirement.
    always_ff @(posedge clk)
    begin
        if (ret_we)
        begin
            retired_mem[retire_slot_reg] <= active_session_reg;
        end
        ret_rd_reg <= retired_mem[scan_idx_reg];
    end

    // Stream sequence memory: read once the stream is known, written back on acceptance.
    always_ff @(posedge clk)
    begin
        if (str_we)
        begin
            stream_mem[sidx_reg] <= seq_reg;
        end
        str_rd_reg <= stream_mem[sidx_reg];
    end

endmodule

// ===== sv/srsg_checker.sv =====
// Port-level checker for the session replay sequence gate, with its bind statement.
module srsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [1:0]  verdict
);
    import srsg_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(accepted))
        else $error("result changed while stalled");

    // The accept flag agrees with the verdict, and the unused code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (verdict == VERDICT_OK)) && (verdict != VERDICT_UNUSED))
        else $error("accept flag and verdict disagree");

    // A frame keeps the block busy for the cycle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in succession");

    // While the controller is idle no verdict is being loaded, so a result taken then is not
    // followed directly by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready |=> !out_valid)
        else $error("result repeated or invented");

endmodule

bind session_replay_sequence_gate srsg_checker u_srsg_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the session replay sequence gate.
module testbench;

    import srsg_pkg::*;

    // Sizes of the gate under test; the predictor below is built at the same sizes.
    localparam int STREAMS = 4;
    localparam int RING = 16;
    // Sessions that the random part keeps revisiting, so that retired sessions recur.
    localparam int POOL = 20;
    localparam int RANDOM_FRAMES = 600;
    // A correct run ends before this limit is reached, even with the longest stalls.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [63:0] sid;
        logic [7:0]  strm;
        logic [31:0] seq;
        bit          fixed;
        verdict_t    fixed_verdict;
    } directed_row_t;

    typedef struct {
        logic        accepted;
        verdict_t    verdict;
        logic [63:0] sid;
        logic [31:0] seq;
    } verdict_rec_t;

    typedef enum {
        RX_OPEN,
        RX_CHOPPY,
        RX_PATTERN,
        RX_STARVED
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] frame_session;
    logic [7:0]  stream;
    logic [31:0] sequence_req;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        accepted;
    verdict_t    verdict;

    // Predictor state: the active session, one record per stream and the ring of retired
    // sessions with its write pointer.
    logic        gate_live;
    logic [63:0] gate_session;
    logic        lane_seen [STREAMS];
    logic [31:0] lane_last [STREAMS];
    logic [63:0] retired_sid [RING];
    logic        retired_used [RING];
    int unsigned retired_next;

    directed_row_t directed_rows [$];
    verdict_rec_t  verdicts_due [$];
    logic [63:0]   sid_pool [POOL];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            burst_left = 0;

    session_replay_sequence_gate #(
        .STREAM_COUNT  (STREAMS),
        .RETIRED_DEPTH (RING)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_session (frame_session),
        .stream        (stream),
        .sequence_req  (sequence_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .verdict       (verdict)
    );

    always #5 clk = ~clk;

    // Works out the verdict for one frame and moves the predictor state on, just as the gate
    // does when it takes the frame.
    function automatic verdict_t judge_frame(input logic [63:0] sid, input logic [7:0] strm,
                                             input logic [31:0] seq);
        int          lane;
        logic [31:0] gap;
        logic        hit;
        hit = 1'b0;
        // Only ring entries that have been written take part in the search.
        for (int i = 0; i < RING; i++)
        begin
            if (retired_used[i] && retired_sid[i] == sid)
                hit = 1'b1;
        end
        if (hit)
            return VERDICT_RETIRED;
        if (!gate_live || gate_session != sid)
        begin
            // A new session pushes the active one into the ring, over the oldest entry
            // once the ring is full, and wipes every stream record.
            if (gate_live)
            begin
                retired_sid[retired_next] = gate_session;
                retired_used[retired_next] = 1'b1;
                retired_next = (retired_next + 1) % RING;
            end
            gate_live = 1'b1;
            gate_session = sid;
            for (int i = 0; i < STREAMS; i++)
            begin
                lane_seen[i] = 1'b0;
                lane_last[i] = '0;
            end
        end
        lane = (strm < STREAMS) ? strm : 0;
        // Serial-number arithmetic: newer means a non-zero forward distance below half the
        // number space, so a distance of exactly half is stale.
        gap = seq - lane_last[lane];
        if (!lane_seen[lane] || (gap != 0 && gap < 32'h8000_0000))
        begin
            lane_seen[lane] = 1'b1;
            lane_last[lane] = seq;
            return VERDICT_OK;
        end
        return VERDICT_STALE;
    endfunction

    function automatic void add_row(input logic [63:0] sid, input logic [7:0] strm,
                                    input logic [31:0] seq, input bit fixed,
                                    input verdict_t fixed_verdict);
        directed_row_t row;
        row.sid = sid;
        row.strm = strm;
        row.seq = seq;
        row.fixed = fixed;
        row.fixed_verdict = fixed_verdict;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Offers one frame and waits for its transfer. The sender works in bursts: when a burst
    // is used up, valid drops for a random gap, sometimes of no length at all, so that gaps
    // land on every phase of the gate's work. Within a burst valid stays high from one frame
    // to the next and only the payload changes.
    task automatic transfer_frame(input logic [63:0] sid, input logic [7:0] strm,
                                  input logic [31:0] seq, input bit fixed,
                                  input verdict_t fixed_verdict);
        int           gap_cycles;
        verdict_t     predicted;
        verdict_rec_t rec;
        if (burst_left == 0)
        begin
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 16);
            if (gap_cycles != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap_cycles - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        frame_session <= sid;
        stream <= strm;
        sequence_req <= seq;
        do
            @(posedge clk);
        while (!in_ready);
        // The transfer has happened at this edge, so the predictor moves on now, and the
        // next frame is chosen from the state that the gate now holds.
        predicted = judge_frame(sid, strm, seq);
        rec.verdict = fixed ? fixed_verdict : predicted;
        rec.accepted = (rec.verdict == VERDICT_OK);
        rec.sid = sid;
        rec.seq = seq;
        verdicts_due = {verdicts_due, rec};
    endtask

    // Takes valid down and holds the sender back until every verdict owed has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        directed_row_t row;
        logic [63:0]   sid;
        logic [7:0]    strm;
        logic [31:0]   seq;
        int            lane;
        int            roll;
        int            slot;
        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_session = '0;
        stream = '0;
        sequence_req = '0;
        gate_live = 1'b0;
        gate_session = '0;
        retired_next = 0;
        for (int i = 0; i < STREAMS; i++)
        begin
            lane_seen[i] = 1'b0;
            lane_last[i] = '0;
        end
        for (int i = 0; i < RING; i++)
        begin
            retired_sid[i] = '0;
            retired_used[i] = 1'b0;
        end
        for (int i = 0; i < POOL; i++)
            sid_pool[i] = {$urandom(), $urandom()};

        // Directed frames. The verdict is typed in where it is plain: the first frame after
        // reset, the two stale boundaries and a retired session. The rest go to the predictor.
        add_row(64'h0, 8'd0, 32'h0000_0000, 1'b1, VERDICT_OK);
        // The same sequence again is not newer.
        add_row(64'h0, 8'd0, 32'h0000_0000, 1'b1, VERDICT_STALE);
        // Exactly half the number space ahead is not newer either.
        add_row(64'h0, 8'd0, 32'h8000_0000, 1'b1, VERDICT_STALE);
        // The largest stream number folds onto stream 0.
        add_row(64'h0, 8'd255, 32'h7FFF_FFFF, 1'b0, VERDICT_OK);
        add_row(64'h0, 8'd3, 32'hFFFF_FFFF, 1'b0, VERDICT_OK);
        // Wrapping from all ones to zero counts as one step forward.
        add_row(64'h0, 8'd3, 32'h0000_0000, 1'b0, VERDICT_OK);
        // A new session retires session zero.
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 32'h0000_0000, 1'b0, VERDICT_OK);
        add_row(64'h0, 8'd2, 32'h0000_0007, 1'b1, VERDICT_RETIRED);
        // The stream records went with the old session, so stream 3 takes anything.
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 8'd3, 32'h0000_0000, 1'b0, VERDICT_OK);
        // Sixteen further sessions fill the ring and then overwrite its oldest entry,
        // which holds session zero, so that session may become active once more.
        for (int k = 1; k <= RING; k++)
            add_row(64'hC0DE_5EED_0000_0000 + k, 8'(k), 32'(k * 32'h0101_0101), 1'b0,
                    VERDICT_OK);
        add_row(64'h0, 8'd4, 32'h0000_0000, 1'b0, VERDICT_OK);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            transfer_frame(row.sid, row.strm, row.seq, row.fixed, row.fixed_verdict);
        end
        hold_until_drained();

        // Random frames. Most stay on the active session and step each stream forward by a
        // little, so the records keep being exercised; the rest replay old numbers, jump by
        // half the space or close to it, switch to sessions that may already be retired, or
        // bring in brand new sessions that churn the ring.
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            roll = $urandom_range(0, 99);
            if (!gate_live || roll < 12)
                sid = sid_pool[$urandom_range(0, POOL - 1)];
            else if (roll < 20)
            begin
                sid = {$urandom(), $urandom()};
                slot = $urandom_range(0, POOL - 1);
                sid_pool[slot] = sid;
            end
            else
                sid = gate_session;
            if ($urandom_range(0, 9) == 0)
                strm = 8'($urandom_range(0, 255));
            else
                strm = 8'($urandom_range(0, STREAMS - 1));
            lane = (strm < STREAMS) ? strm : 0;
            roll = $urandom_range(0, 99);
            if (roll < 65)
                seq = lane_last[lane] + $urandom_range(1, 16);
            else if (roll < 75)
                seq = lane_last[lane] - $urandom_range(0, 4);
            else if (roll < 80)
                seq = lane_last[lane] + 32'h8000_0000;
            else if (roll < 85)
                seq = lane_last[lane] + 32'h7FFF_FFFF + $urandom_range(0, 2);
            else
                seq = $urandom();
            transfer_frame(sid, strm, seq, 1'b0, VERDICT_OK);
            // Halfway through, the sender waits for the gate to empty completely.
            if (n == RANDOM_FRAMES / 2)
                hold_until_drained();
        end

        hold_until_drained();
        // Anything the gate emits after the last verdict owed is caught by the checker.
        repeat (2 * (RING + 3)) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The receiver changes its behaviour every so often: always ready, ready at random,
    // ready on a repeating pattern of its own, or stalling most of the time.
    initial
    begin : receiver
        rx_mode_t    rx_mode;
        logic [15:0] pattern;
        int          phase;
        phase = 0;
        forever
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            pattern = 16'($urandom()) | 16'h0001;
            repeat ($urandom_range(20, 120))
            begin
                @(negedge clk);
                case (rx_mode)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_CHOPPY:  out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: out_ready <= pattern[phase % 16];
                    default:    out_ready <= ($urandom_range(0, 7) == 0);
                endcase
                phase++;
            end
        end
    end

    // Each verdict transfer is compared field by field with the oldest verdict owed.
    always @(posedge clk)
    begin : verdict_check
        verdict_rec_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch($sformatf("verdict %0d with no frame outstanding", verdict));
            else
            begin
                due = verdicts_due.pop_front();
                if (accepted !== due.accepted)
                    report_mismatch($sformatf("session %h sequence %h: accepted %b, wanted %b",
                                              due.sid, due.seq, accepted, due.accepted));
                if (verdict !== due.verdict)
                    report_mismatch($sformatf("session %h sequence %h: verdict %0d, wanted %0d",
                                              due.sid, due.seq, verdict, due.verdict));
            end
        end
    end

    // Watchdog: a run that hangs anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
